### hw/rtl/omni_wheel_mixer_normalized_assert.svh
// Assertion macros shared by the omni-wheel mixer RTL.
// No dependencies; included inside module bodies.
`ifndef OMNI_WHEEL_MIXER_NORMALIZED_ASSERT_SVH
`define OMNI_WHEEL_MIXER_NORMALIZED_ASSERT_SVH

// Same-cycle implication, held off during reset
`define OWMN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("omni wheel mixer: same-cycle check failed");

// Next-cycle implication, held off during reset
`define OWMN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("omni wheel mixer: next-cycle check failed");

`endif

### hw/rtl/owmn_pkg.sv
// Shared widths, direction codes and the divider word for the omni-wheel mixer.
// No dependencies.
package owmn_pkg;

  localparam int unsigned NUM_W    = 4;   // wheels
  localparam int unsigned NUM_AX   = 3;   // x, y, rotation
  localparam int unsigned CMD_W    = 15;  // signed command width
  localparam int unsigned SUM_W    = 17;  // signed wheel sum
  localparam int unsigned MAG_W    = 16;  // |sum| <= 49152
  localparam int unsigned DUTY_W   = 14;  // ceiling and duty width
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned REM_W    = MAG_W + DUTY_W - 1 + 1; // |sum| * ceiling < 2^30
  localparam int unsigned WHEEL_W  = DUTY_W + DIR_W;
  localparam int unsigned IN_RAW_W = 3 * CMD_W + DUTY_W;
  localparam int unsigned IN_TD_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int unsigned OUT_TD_W = ((NUM_W * WHEEL_W + 7) / 8) * 8;

  // Axis negation per wheel, bit 0 = x, bit 1 = y, bit 2 = rotation
  localparam logic [NUM_W-1:0][NUM_AX-1:0] MIX_NEG = {3'b000, 3'b001, 3'b011, 3'b010};

  typedef enum logic [DIR_W-1:0] {
    DIR_BRAKE    = 2'd0,
    DIR_FORWARD  = 2'd1,
    DIR_BACKWARD = 2'd2
  } owmn_dir_e;

  // Word handed along the divider row
  typedef struct packed {
    logic [NUM_W-1:0][REM_W-1:0]  rem;
    logic [NUM_W-1:0][DUTY_W-1:0] quo;
    logic [MAG_W-1:0]             peak;
    logic [NUM_W-1:0]             neg;
  } owmn_div_t;

endpackage

### hw/rtl/owmn_front.sv
// Front end: wheel mixing, magnitudes, peak search and numerator products.
// Depends on owmn_pkg.
module owmn_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           din_valid_i,
  output logic                           din_ready_o,
  input  logic [owmn_pkg::CMD_W-1:0]     move_x_i,
  input  logic [owmn_pkg::CMD_W-1:0]     move_y_i,
  input  logic [owmn_pkg::CMD_W-1:0]     turn_rate_i,
  input  logic [owmn_pkg::DUTY_W-1:0]    duty_ceiling_i,
  output logic                           dout_valid_o,
  input  logic                           dout_ready_i,
  output owmn_pkg::owmn_div_t            dout_o
);
  import owmn_pkg::*;

  logic                              s1_valid_q;
  logic [NUM_W-1:0][MAG_W-1:0]       mag_q, mag_d;
  logic [NUM_W-1:0]                  neg_q, neg_d;
  logic [DUTY_W-1:0]                 ceil_q;
  logic                              s2_valid_q;
  owmn_div_t                         div_q, div_d;
  logic                              s1_ready, s2_ready;
  logic [NUM_AX-1:0][SUM_W-1:0]      cmd_ext;
  logic [SUM_W-1:0]                  sum;
  logic [MAG_W-1:0]                  pk01, pk23;

  assign s2_ready    = !s2_valid_q || dout_ready_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign din_ready_o = s1_ready;

  // Mix the three commands into four signed sums, then split sign and magnitude
  always_comb begin
    cmd_ext[0] = {{(SUM_W-CMD_W){move_x_i[CMD_W-1]}}, move_x_i};
    cmd_ext[1] = {{(SUM_W-CMD_W){move_y_i[CMD_W-1]}}, move_y_i};
    cmd_ext[2] = {{(SUM_W-CMD_W){turn_rate_i[CMD_W-1]}}, turn_rate_i};
    sum   = '0;
    mag_d = '0;
    neg_d = '0;
    for (int j = 0; j < NUM_W; j++) begin
      sum = '0;
      for (int a = 0; a < NUM_AX; a++) begin
        sum = MIX_NEG[j][a] ? (sum - cmd_ext[a]) : (sum + cmd_ext[a]);
      end
      neg_d[j] = sum[SUM_W-1];
      mag_d[j] = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    end
  end

  // Peak magnitude and the four numerators |sum| * ceiling
  always_comb begin
    pk01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
    pk23 = (mag_q[2] > mag_q[3]) ? mag_q[2] : mag_q[3];
    div_d      = '0;
    div_d.peak = (pk01 > pk23) ? pk01 : pk23;
    div_d.neg  = neg_q;
    for (int j = 0; j < NUM_W; j++) begin
      div_d.rem[j] = {{(REM_W-MAG_W){1'b0}}, mag_q[j]}
                   * {{(REM_W-DUTY_W){1'b0}}, ceil_q};
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= din_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (s1_ready && din_valid_i) begin
      mag_q  <= mag_d;
      neg_q  <= neg_d;
      ceil_q <= duty_ceiling_i;
    end
    if (s2_ready && s1_valid_q) begin
      div_q <= div_d;
    end
  end

  assign dout_valid_o = s2_valid_q;
  assign dout_o       = div_q;

endmodule

### hw/rtl/owmn_cell.sv
// One restoring-division cell: settles one quotient bit for all four wheels.
// Depends on owmn_pkg.
module owmn_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                din_valid_i,
  output logic                din_ready_o,
  input  owmn_pkg::owmn_div_t din_i,
  output logic                dout_valid_o,
  input  logic                dout_ready_i,
  output owmn_pkg::owmn_div_t dout_o
);
  import owmn_pkg::*;

  logic             valid_q;
  owmn_div_t        cell_q, cell_d;
  logic [REM_W-1:0] dsh;

  assign din_ready_o = !valid_q || dout_ready_i;

  // Trial subtract of peak << BIT per wheel
  always_comb begin
    dsh    = REM_W'(din_i.peak) << BIT;
    cell_d = din_i;
    for (int j = 0; j < NUM_W; j++) begin
      if (din_i.rem[j] >= dsh) begin
        cell_d.rem[j]      = din_i.rem[j] - dsh;
        cell_d.quo[j][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (din_ready_o) begin
      valid_q <= din_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (din_ready_o && din_valid_i) begin
      cell_q <= cell_d;
    end
  end

  assign dout_valid_o = valid_q;
  assign dout_o       = cell_q;

endmodule

### hw/rtl/omni_wheel_mixer_normalized.sv
// Channel   | dir | fields (lowest bit first)
// s_axis    | in  | move_x[14:0] move_y[29:15] turn_rate[44:30] duty_ceiling[58:45]
// m_axis    | out | per wheel n: duty[16n+13:16n] dir[16n+15:16n+14]
//
// One word per cycle sustained while the output is taken; the path runs through two
// front stages, a row of 14 divider cells, one quotient bit each, and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// Each stage holds when the next is full, so bubbles close up while the
// output waits; tready is the OR of stage-empty terms down the row.
// Depends on owmn_pkg, owmn_front, owmn_cell and the assertion header.
module omni_wheel_mixer_normalized (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [owmn_pkg::IN_TD_W-1:0]  s_axis_tdata,  // move_x, move_y, turn_rate, duty_ceiling
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [owmn_pkg::OUT_TD_W-1:0] m_axis_tdata   // wheel0..3: duty, dir
);
  import owmn_pkg::*;
  `include "omni_wheel_mixer_normalized_assert.svh"

  owmn_div_t                  stage_data  [0:DUTY_W];
  logic      [DUTY_W:0]       stage_valid;
  logic      [DUTY_W:0]       stage_ready;
  logic                       out_valid_q;
  logic      [OUT_TD_W-1:0]   out_data_q, out_data_d;
  logic      [NUM_W-1:0]      brake_ok;
  logic      [DUTY_W-1:0]     duty;
  owmn_dir_e                  dir;
  logic                       row_valid, row_hold, row_peak_zero;
  logic                       row_rem_ok, row_rem_zero;

  // Mixing and numerator stages
  owmn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .din_valid_i    (s_axis_tvalid),
    .din_ready_o    (s_axis_tready),
    .move_x_i       (s_axis_tdata[CMD_W-1:0]),
    .move_y_i       (s_axis_tdata[2*CMD_W-1:CMD_W]),
    .turn_rate_i    (s_axis_tdata[3*CMD_W-1:2*CMD_W]),
    .duty_ceiling_i (s_axis_tdata[IN_RAW_W-1:3*CMD_W]),
    .dout_valid_o   (stage_valid[0]),
    .dout_ready_i   (stage_ready[0]),
    .dout_o         (stage_data[0])
  );

  // Divider row, most significant quotient bit first
  for (genvar g = 0; g < DUTY_W; g++) begin : g_cell
    owmn_cell #(
      .BIT (DUTY_W - 1 - g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .din_valid_i  (stage_valid[g]),
      .din_ready_o  (stage_ready[g]),
      .din_i        (stage_data[g]),
      .dout_valid_o (stage_valid[g+1]),
      .dout_ready_i (stage_ready[g+1]),
      .dout_o       (stage_data[g+1])
    );
  end

  assign stage_ready[DUTY_W] = !out_valid_q || m_axis_tready;

  // Duty and direction per wheel; a zero peak gives brake everywhere
  always_comb begin
    out_data_d = '0;
    duty       = '0;
    dir        = DIR_BRAKE;
    for (int j = 0; j < NUM_W; j++) begin
      duty = (stage_data[DUTY_W].peak == '0) ? '0 : stage_data[DUTY_W].quo[j];
      if (duty == '0)                      dir = DIR_BRAKE;
      else if (stage_data[DUTY_W].neg[j])  dir = DIR_BACKWARD;
      else                                 dir = DIR_FORWARD;
      out_data_d[j*WHEEL_W +: DUTY_W]       = duty;
      out_data_d[j*WHEEL_W+DUTY_W +: DIR_W] = dir;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_ready[DUTY_W]) begin
      out_valid_q <= stage_valid[DUTY_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_ready[DUTY_W] && stage_valid[DUTY_W]) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Brake code exactly when duty is zero
  always_comb begin
    for (int j = 0; j < NUM_W; j++) begin
      brake_ok[j] = (m_axis_tdata[j*WHEEL_W+DUTY_W +: DIR_W] == DIR_BRAKE)
                 == (m_axis_tdata[j*WHEEL_W +: DUTY_W] == '0);
    end
  end

  // Row-end terms for the checks below
  assign row_valid     = stage_valid[DUTY_W];
  assign row_hold      = stage_valid[DUTY_W] && !stage_ready[DUTY_W];
  assign row_peak_zero = (stage_data[DUTY_W].peak == '0);
  assign row_rem_ok    = stage_data[DUTY_W].rem[0] < REM_W'(stage_data[DUTY_W].peak);
  assign row_rem_zero  = (stage_data[DUTY_W].rem == '0);

  `OWMN_ASSERT_IMPL(a_rem_below_peak, clk_i, rst_ni, row_valid && !row_peak_zero, row_rem_ok)
  `OWMN_ASSERT_IMPL(a_zero_peak_no_rem, clk_i, rst_ni, row_valid && row_peak_zero, row_rem_zero)
  `OWMN_ASSERT_IMPL(a_brake_iff_zero, clk_i, rst_ni, m_axis_tvalid, &brake_ok)
  `OWMN_ASSERT_NEXT(a_row_end_holds, clk_i, rst_ni, row_hold, row_valid)

endmodule

### tb/tb_omni_wheel_mixer_normalized.sv
// Self-checking testbench for the four-wheel omni-drive mixer with duty normalisation.
// It has its own mixing and scaling predictor and a word-by-word result checker.
// Depends on owmn_pkg and the omni_wheel_mixer_normalized RTL.
module tb_omni_wheel_mixer_normalized;
  import owmn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;   // drain margin beyond the pipeline depth

  // Command word, laid out exactly as the input tdata (sideways in the low bits)
  typedef struct packed {
    logic [13:0] ceiling;
    logic [14:0] turn;
    logic [14:0] fwd;
    logic [14:0] side;
  } motion_cmd_t;

  // Per-wheel outputs, as predicted
  typedef struct packed {
    logic [3:0][13:0] duty;
    owmn_dir_e [3:0]  dir;
  } wheel_set_t;

  // Sign of the x and y axes per wheel; rotation always adds
  localparam int SIDE_SIGN [4] = '{1, -1, -1, 1};
  localparam int FWD_SIGN  [4] = '{-1, -1, 1, 1};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_TD_W-1:0]    s_axis_tdata;   // move_x, move_y, turn_rate, duty_ceiling
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_TD_W-1:0]   m_axis_tdata;   // wheel0..3: duty, dir

  wheel_set_t  wheel_q[$];
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned tx_max_gap;
  int unsigned rx_max_wait;
  int unsigned rx_wait;
  int unsigned rx_hold;

  omni_wheel_mixer_normalized dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("omni_wheel_mixer_normalized regression: fail");
      $finish;
    end
  end

  // Mix the three axes into four wheel sums and scale by ceiling over the peak
  function automatic wheel_set_t mix_and_scale(motion_cmd_t cmd);
    wheel_set_t res;
    int         sum [4];
    longint     mag [4];
    longint     peak;
    longint     duty;
    int         side;
    int         fwd;
    int         turn;
    side = int'($signed(cmd.side));
    fwd  = int'($signed(cmd.fwd));
    turn = int'($signed(cmd.turn));
    peak = 0;
    for (int n = 0; n < 4; n++) begin
      sum[n] = SIDE_SIGN[n] * side + FWD_SIGN[n] * fwd + turn;
      mag[n] = longint'((sum[n] < 0) ? -sum[n] : sum[n]);
      if (mag[n] > peak) peak = mag[n];
    end
    for (int n = 0; n < 4; n++) begin
      // all sums zero: no division, every wheel brakes
      duty = (peak == 0) ? 0 : (mag[n] * longint'(cmd.ceiling)) / peak;
      res.duty[n] = duty[13:0];
      if (duty == 0) begin
        res.dir[n] = DIR_BRAKE;
      end else if (sum[n] < 0) begin
        res.dir[n] = DIR_BACKWARD;
      end else begin
        res.dir[n] = DIR_FORWARD;
      end
    end
    return res;
  endfunction

  // Receiver: per-word random wait, plus a long hold when requested
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin
    wheel_set_t want;
    logic [13:0] got_duty;
    logic [1:0]  got_dir;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_wait = $urandom_range(0, rx_max_wait);
      if (wheel_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        want = wheel_q.pop_front();
        for (int n = 0; n < 4; n++) begin
          got_duty = m_axis_tdata[16*n +: 14];
          got_dir  = m_axis_tdata[16*n+14 +: 2];
          if (got_duty !== want.duty[n]) begin
            $display("%0t: wheel %0d duty, expected %0d, actual %0d",
                     $time, n, want.duty[n], got_duty);
            err_count++;
          end
          if (got_dir !== want.dir[n]) begin
            $display("%0t: wheel %0d dir, expected %0d, actual %0d",
                     $time, n, want.dir[n], got_dir);
            err_count++;
          end
        end
      end
    end
  end

  // Offer one command after a gap; tvalid stays high afterwards for back-to-back words
  task automatic send_cmd(motion_cmd_t cmd, int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TD_W - $bits(motion_cmd_t)){1'b0}}, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    wheel_q.push_back(mix_and_scale(cmd));
  endtask

  task automatic send_random_gap(motion_cmd_t cmd);
    send_cmd(cmd, $urandom_range(0, tx_max_gap));
  endtask

  task automatic idle_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (wheel_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic motion_cmd_t make_cmd(int side, int fwd, int turn, int ceiling);
    motion_cmd_t cmd;
    cmd.side    = side[14:0];
    cmd.fwd     = fwd[14:0];
    cmd.turn    = turn[14:0];
    cmd.ceiling = ceiling[13:0];
    return cmd;
  endfunction

  function automatic int pick_edge_axis();
    case ($urandom_range(0, 4))
      0: return -16384;
      1: return -1;
      2: return 0;
      3: return 1;
      default: return 16383;
    endcase
  endfunction

  function automatic int small_axis();
    return int'($urandom_range(0, 16)) - 8;
  endfunction

  // Random command, weighted towards cancelling sums, extremes and odd ceilings
  function automatic motion_cmd_t rand_cmd();
    motion_cmd_t cmd;
    logic [63:0] raw;
    int          v;
    raw = {$urandom, $urandom};
    cmd = raw[$bits(motion_cmd_t)-1:0];
    case ($urandom_range(0, 9))
      5: begin
        cmd.side = 15'(small_axis());
        cmd.fwd  = 15'(small_axis());
        cmd.turn = 15'(small_axis());
      end
      6: begin
        // partial cancellation: two wheels see only the turn term, a zero sum when it is cleared
        v = int'($urandom_range(0, 32767)) - 16384;
        cmd.fwd  = cmd.side;
        cmd.turn = (v[0]) ? 15'd0 : cmd.turn;
      end
      7: begin
        cmd.side = 15'(pick_edge_axis());
        cmd.fwd  = 15'(pick_edge_axis());
        cmd.turn = 15'(pick_edge_axis());
      end
      8: begin
        case ($urandom_range(0, 3))
          0: cmd.ceiling = 14'd0;
          1: cmd.ceiling = 14'd1;
          2: cmd.ceiling = 14'd9999;
          default: cmd.ceiling = 14'h3fff;
        endcase
      end
      9: begin
        cmd.side = '0;
        cmd.fwd  = '0;
        cmd.turn = '0;
      end
      default: ;
    endcase
    // most ceilings in the nominal duty range
    if ($urandom_range(0, 3) != 0 && cmd.ceiling > 14'd9999) begin
      cmd.ceiling = 14'($urandom_range(0, 9999));
    end
    return cmd;
  endfunction

  // Extremes, single axes, zero sums and truncation to brake
  task automatic test_directed();
    motion_cmd_t cmds[$];
    tx_max_gap  = 3;
    rx_max_wait = 3;
    cmds.push_back(make_cmd(0, 0, 0, 9999));
    cmds.push_back(make_cmd(0, 0, 0, 0));
    cmds.push_back(make_cmd(16383, 0, 0, 9999));
    cmds.push_back(make_cmd(-16384, 0, 0, 9999));
    cmds.push_back(make_cmd(0, 16383, 0, 9999));
    cmds.push_back(make_cmd(0, -16384, 0, 9999));
    cmds.push_back(make_cmd(0, 0, 16383, 9999));
    cmds.push_back(make_cmd(0, 0, -16384, 9999));
    cmds.push_back(make_cmd(16383, -16384, 16383, 16383));
    cmds.push_back(make_cmd(-16384, -16384, 16383, 16383));
    cmds.push_back(make_cmd(-16384, 16383, -16384, 9999));
    cmds.push_back(make_cmd(-16384, -16384, -16384, 16383));
    cmds.push_back(make_cmd(16383, 16383, 16383, 1));
    cmds.push_back(make_cmd(1234, -567, 89, 0));
    cmds.push_back(make_cmd(16383, 16383, 1, 9999));
    cmds.push_back(make_cmd(-1, -1, -1, 1));
    cmds.push_back(make_cmd(1, 0, 0, 1));
    cmds.push_back(make_cmd(5000, 5000, 0, 7777));
    cmds.push_back(make_cmd(3, -7, 2, 16383));
    cmds.push_back(make_cmd(-12000, 4000, 9000, 5000));
    foreach (cmds[i]) send_random_gap(cmds[i]);
    idle_sender();
    wait_drained();
  endtask

  // Receiver holds off for a long stretch while words keep coming
  task automatic test_backpressure();
    tx_max_gap  = 0;
    rx_max_wait = 0;
    @(negedge clk_i);
    rx_hold = 200;
    repeat (40) send_cmd(rand_cmd(), 0);
    idle_sender();
    wait_drained();
  endtask

  // Random commands across idling patterns, with a full drain part-way
  task automatic test_random();
    int unsigned gap_mode [5] = '{0, 19, 0, 19, 3};
    int unsigned rx_mode  [5] = '{0, 0, 19, 19, 3};
    for (int i = 0; i < 390; i++) begin
      if (i % 50 == 0) begin
        tx_max_gap  = gap_mode[(i / 50) % 5];
        rx_max_wait = rx_mode[(i / 50) % 5];
      end
      // sender pauses until the pipeline has emptied
      if (i == 200) begin
        idle_sender();
        wait_drained();
      end
      send_random_gap(rand_cmd());
    end
    idle_sender();
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    err_count     = 0;
    cycle_count   = 0;
    tx_max_gap    = 0;
    rx_max_wait   = 0;
    rx_wait       = 0;
    rx_hold       = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_backpressure();
    test_random();

    // let any stray word surface
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0 && wheel_q.size() == 0) begin
      $display("omni_wheel_mixer_normalized regression: pass");
    end else begin
      $display("omni_wheel_mixer_normalized regression: fail");
    end
    $finish;
  end

endmodule
